// ===== hw/rtl/lus_pkg.sv =====
// ----------------------------------------------------------------------------
// lus_pkg
// Shared types and constants of the fixed-point LU solve unit.
// ----------------------------------------------------------------------------
package lus_pkg;

  localparam int MAX_ORDER = 16;
  localparam int IDX_W     = 4;            // row / column index
  localparam int CNT_W     = IDX_W + 1;    // counter that can hold the order itself
  localparam int VAL_W     = 32;           // Q16.16 value
  localparam int FRAC_W    = 16;
  localparam int DVD_W     = VAL_W + FRAC_W;
  localparam int SIZE_W    = 5;
  localparam int MAT_AW    = 2 * IDX_W;
  localparam int VEC_AW    = IDX_W + 2;

  // item actions
  localparam logic [1:0] ACT_MAT   = 2'd0;
  localparam logic [1:0] ACT_RHS   = 2'd1;
  localparam logic [1:0] ACT_SOLVE = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;   // unused code, item is dropped

  typedef struct packed {
    logic [1:0]              action;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] solution;
    logic                    last;
    logic                    singular;
  } out_item_t;

endpackage

// ===== hw/rtl/lus_ram.sv =====
// ----------------------------------------------------------------------------
// lus_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module lus_ram #(
  parameter int AW = 8,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lus_div.sv =====
// ----------------------------------------------------------------------------
// lus_div
// Q16.16 divider, restoring, one quotient bit per cycle, truncates toward
// zero and saturates; a zero divisor gives the limit of the numerator's sign, or zero for a zero numerator.
// ----------------------------------------------------------------------------
module lus_div import lus_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] num,
  input  logic signed [VAL_W-1:0] den,
  output logic                    done,
  output logic signed [VAL_W-1:0] quo,
  output logic                    zero_den
);

  localparam logic [5:0] LAST_STEP = 6'(DVD_W - 1);

  logic             busy;
  logic             fin;
  logic [5:0]       cnt;
  logic [VAL_W-1:0] rem;
  logic [VAL_W-1:0] dmag;
  logic [DVD_W-1:0] dvd;
  logic             neg;
  logic [VAL_W:0]   shifted;
  logic [VAL_W:0]   diff;
  logic             ge;
  logic [VAL_W-1:0] nmag;
  logic [VAL_W-1:0] dmag_in;

  // one restoring step
  always_comb begin
    shifted = {rem, dvd[DVD_W-1]};
    diff    = shifted - {1'b0, dmag};
    ge      = shifted >= {1'b0, dmag};
    nmag    = num[VAL_W-1] ? (~num + 1'b1) : num;
    dmag_in = den[VAL_W-1] ? (~den + 1'b1) : den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        zero_den <= (den == '0);
        if (den == '0) begin
          done <= 1'b1;
          if (num[VAL_W-1]) begin
            quo <= {1'b1, {(VAL_W-1){1'b0}}};
          end else if (num != '0) begin
            quo <= {1'b0, {(VAL_W-1){1'b1}}};
          end else begin
            quo <= '0;
          end
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
          rem  <= '0;
          dmag <= dmag_in;
          dvd  <= {nmag, {FRAC_W{1'b0}}};
          neg  <= num[VAL_W-1] ^ den[VAL_W-1];
        end
      end else if (busy) begin
        rem <= ge ? diff[VAL_W-1:0] : shifted[VAL_W-1:0];
        dvd <= {dvd[DVD_W-2:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        // sign and saturation
        fin  <= 1'b0;
        done <= 1'b1;
        if (neg) begin
          if (dvd > DVD_W'({1'b1, {(VAL_W-1){1'b0}}})) begin
            quo <= {1'b1, {(VAL_W-1){1'b0}}};
          end else begin
            quo <= ~dvd[VAL_W-1:0] + 1'b1;
          end
        end else begin
          if (dvd > DVD_W'({1'b0, {(VAL_W-1){1'b1}}})) begin
            quo <= {1'b0, {(VAL_W-1){1'b1}}};
          end else begin
            quo <= dvd[VAL_W-1:0];
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/lu_decomposition_solve_unit.sv =====
// ----------------------------------------------------------------------------
// lu_decomposition_solve_unit
// Q16.16 Crout LU solver over a matrix RAM and a vector RAM.
// Load items are accepted while the unit is idle. A solve works through
// about n^3/3 multiply-add terms one at a time and n(n+1)/2 divisions in the
// shared divider, then emits its result items; input is stalled from the
// solve item until the last result item is taken.
// Reset clears control, the singular flag and sets the order to 16; the RAM
// contents are not cleared.
// ----------------------------------------------------------------------------
module lu_decomposition_solve_unit import lus_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output out_item_t       out_item,
  input  logic            cfg_write,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int ACC_W = 53;
  localparam int ST_W  = 5;

  localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] ST_PIV_RD   = 5'd1;
  localparam logic [ST_W-1:0] ST_PIV_CHK  = 5'd2;
  localparam logic [ST_W-1:0] ST_SRCH_RD  = 5'd3;
  localparam logic [ST_W-1:0] ST_SRCH_CHK = 5'd4;
  localparam logic [ST_W-1:0] ST_FIX_RDA  = 5'd5;
  localparam logic [ST_W-1:0] ST_FIX_RDB  = 5'd6;
  localparam logic [ST_W-1:0] ST_FIX_WR   = 5'd7;
  localparam logic [ST_W-1:0] ST_RFIX_RDA = 5'd8;
  localparam logic [ST_W-1:0] ST_RFIX_RDB = 5'd9;
  localparam logic [ST_W-1:0] ST_RFIX_WR  = 5'd10;
  localparam logic [ST_W-1:0] ST_JOB_BASE = 5'd11;
  localparam logic [ST_W-1:0] ST_JOB_BASEW = 5'd12;
  localparam logic [ST_W-1:0] ST_JOB_DIVW = 5'd13;
  localparam logic [ST_W-1:0] ST_TERM_A   = 5'd14;
  localparam logic [ST_W-1:0] ST_TERM_B   = 5'd15;
  localparam logic [ST_W-1:0] ST_TERM_MUL = 5'd16;
  localparam logic [ST_W-1:0] ST_TERM_ACC = 5'd17;
  localparam logic [ST_W-1:0] ST_JOB_FIN  = 5'd18;
  localparam logic [ST_W-1:0] ST_DIV_WAIT = 5'd19;
  localparam logic [ST_W-1:0] ST_JOB_WR   = 5'd20;
  localparam logic [ST_W-1:0] ST_OUT_RD   = 5'd21;
  localparam logic [ST_W-1:0] ST_OUT_LD   = 5'd22;
  localparam logic [ST_W-1:0] ST_OUT_WAIT = 5'd23;

  // solve phases
  localparam logic [1:0] PH_COL  = 2'd0;
  localparam logic [1:0] PH_ROW  = 2'd1;
  localparam logic [1:0] PH_FWD  = 2'd2;
  localparam logic [1:0] PH_BACK = 2'd3;

  // vector RAM regions
  localparam logic [1:0] VSEL_RHS = 2'd0;
  localparam logic [1:0] VSEL_FWD = 2'd1;
  localparam logic [1:0] VSEL_SOL = 2'd2;

  localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);
  localparam logic [SIZE_W-1:0] SIZE_CAP = SIZE_W'(MAX_ORDER);

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
    lo = {{(ACC_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
    if (v > hi) begin
      return hi[VAL_W-1:0];
    end else if (v < lo) begin
      return lo[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

  logic [ST_W-1:0]          state;
  logic [1:0]               phase;
  logic [CNT_W-1:0]         k;
  logic [CNT_W-1:0]         i;
  logic [CNT_W-1:0]         p;
  logic [CNT_W-1:0]         t;
  logic [SIZE_W-1:0]        matrix_size;
  logic [CNT_W-1:0]         n;
  logic signed [VAL_W-1:0]  a_reg;
  logic signed [VAL_W-1:0]  div_reg;
  logic signed [VAL_W-1:0]  res_reg;
  logic signed [2*VAL_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     sing_seen;

  logic                     in_acc;
  logic                     out_acc;

  // RAM ports
  logic                     m_we;
  logic [MAT_AW-1:0]        m_waddr;
  logic [VAL_W-1:0]         m_wdata;
  logic [MAT_AW-1:0]        m_raddr;
  logic [VAL_W-1:0]         m_rdata;
  logic                     v_we;
  logic [VEC_AW-1:0]        v_waddr;
  logic [VAL_W-1:0]         v_wdata;
  logic [VEC_AW-1:0]        v_raddr;
  logic [VAL_W-1:0]         v_rdata;
  logic signed [VAL_W-1:0]  mrd;
  logic signed [VAL_W-1:0]  vrd;
  logic signed [VAL_W-1:0]  brd;

  // current multiply-accumulate job
  logic [CNT_W-1:0]         job_ar;
  logic                     job_bvec;
  logic [1:0]               job_bsel;
  logic [CNT_W-1:0]         job_bcol;
  logic                     job_div;
  logic [CNT_W-1:0]         job_t0;
  logic [CNT_W-1:0]         job_tend;
  logic                     job_on_mat;
  logic [MAT_AW-1:0]        job_maddr;
  logic [VEC_AW-1:0]        job_vbase;
  logic [VEC_AW-1:0]        job_vdst;
  logic [MAT_AW-1:0]        job_daddr;

  logic                     div_start;
  logic                     div_done;
  logic signed [VAL_W-1:0]  div_quo;
  logic                     div_zero;
  logic signed [VAL_W-1:0]  acc_sat;

  assign n         = CNT_W'(matrix_size);
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign mrd       = $signed(m_rdata);
  assign vrd       = $signed(v_rdata);
  assign brd       = job_bvec ? vrd : mrd;
  assign acc_sat   = sat32(acc);
  assign div_start = (state == ST_JOB_FIN) && job_div;

  // job description per phase
  always_comb begin
    job_ar     = i;
    job_bvec   = 1'b0;
    job_bsel   = VSEL_FWD;
    job_bcol   = k;
    job_div    = 1'b0;
    job_t0     = '0;
    job_tend   = k;
    job_maddr  = {i[IDX_W-1:0], k[IDX_W-1:0]};
    job_daddr  = {i[IDX_W-1:0], i[IDX_W-1:0]};
    job_vbase  = {VSEL_RHS, i[IDX_W-1:0]};
    job_vdst   = {VSEL_FWD, i[IDX_W-1:0]};
    unique case (phase)
      PH_COL: begin
        job_ar = i;
      end
      PH_ROW: begin
        job_ar    = k;
        job_bcol  = i;
        job_div   = 1'b1;
        job_maddr = {k[IDX_W-1:0], i[IDX_W-1:0]};
        job_daddr = {k[IDX_W-1:0], k[IDX_W-1:0]};
      end
      PH_FWD: begin
        job_bvec = 1'b1;
        job_bsel = VSEL_FWD;
        job_div  = 1'b1;
        job_tend = i;
      end
      PH_BACK: begin
        job_bvec  = 1'b1;
        job_bsel  = VSEL_SOL;
        job_t0    = i + ONE;
        job_tend  = n;
        job_vbase = {VSEL_FWD, i[IDX_W-1:0]};
        job_vdst  = {VSEL_SOL, i[IDX_W-1:0]};
      end
    endcase
    job_on_mat = (phase == PH_COL) || (phase == PH_ROW);
  end

  // RAM addressing per state
  always_comb begin
    m_we    = 1'b0;
    m_waddr = job_maddr;
    m_wdata = res_reg;
    m_raddr = job_maddr;
    v_we    = 1'b0;
    v_waddr = job_vdst;
    v_wdata = res_reg;
    v_raddr = job_vbase;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_item.action == ACT_MAT) begin
          m_we    = 1'b1;
          m_waddr = {in_item.row, in_item.col};
          m_wdata = in_item.value;
        end
        if (in_acc && in_item.action == ACT_RHS) begin
          v_we    = 1'b1;
          v_waddr = {VSEL_RHS, in_item.row};
          v_wdata = in_item.value;
        end
      end
      ST_PIV_RD:   m_raddr = {k[IDX_W-1:0], k[IDX_W-1:0]};
      ST_SRCH_RD:  m_raddr = {p[IDX_W-1:0], k[IDX_W-1:0]};
      ST_FIX_RDA:  m_raddr = {k[IDX_W-1:0], i[IDX_W-1:0]};
      ST_FIX_RDB:  m_raddr = {p[IDX_W-1:0], i[IDX_W-1:0]};
      ST_FIX_WR: begin
        m_we    = 1'b1;
        m_waddr = {k[IDX_W-1:0], i[IDX_W-1:0]};
        m_wdata = sat32(ACC_W'(a_reg) + ACC_W'(mrd));
      end
      ST_RFIX_RDA: v_raddr = {VSEL_RHS, k[IDX_W-1:0]};
      ST_RFIX_RDB: v_raddr = {VSEL_RHS, p[IDX_W-1:0]};
      ST_RFIX_WR: begin
        v_we    = 1'b1;
        v_waddr = {VSEL_RHS, k[IDX_W-1:0]};
        v_wdata = sat32(ACC_W'(a_reg) + ACC_W'(vrd));
      end
      ST_JOB_BASEW: m_raddr = job_daddr;
      ST_TERM_A:   m_raddr = {job_ar[IDX_W-1:0], t[IDX_W-1:0]};
      ST_TERM_B: begin
        m_raddr = {t[IDX_W-1:0], job_bcol[IDX_W-1:0]};
        v_raddr = {job_bsel, t[IDX_W-1:0]};
      end
      ST_JOB_WR: begin
        m_we = job_on_mat;
        v_we = !job_on_mat;
      end
      ST_OUT_RD:   v_raddr = {VSEL_SOL, i[IDX_W-1:0]};
      default: begin
      end
    endcase
  end

  lus_ram #(.AW(MAT_AW), .DW(VAL_W)) u_mat_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  lus_ram #(.AW(VEC_AW), .DW(VAL_W)) u_vec_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  lus_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (acc_sat),
    .den      (div_reg),
    .done     (div_done),
    .quo      (div_quo),
    .zero_den (div_zero)
  );

  // solve sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      sing_seen   <= 1'b0;
      matrix_size <= SIZE_CAP;
    end else begin
      if (cfg_write) begin
        if (cfg_data == '0) begin
          matrix_size <= SIZE_W'(1);
        end else if (cfg_data > SIZE_CAP) begin
          matrix_size <= SIZE_CAP;
        end else begin
          matrix_size <= cfg_data;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc && in_item.action == ACT_SOLVE) begin
            sing_seen <= 1'b0;
            k         <= '0;
            state     <= ST_PIV_RD;
          end
        end
        ST_PIV_RD: state <= ST_PIV_CHK;
        ST_PIV_CHK: begin
          if (mrd != '0) begin
            phase <= PH_COL;
            i     <= k;
            state <= ST_JOB_BASE;
          end else begin
            p     <= k + ONE;
            state <= ST_SRCH_RD;
          end
        end
        ST_SRCH_RD: begin
          if (p >= n) begin
            phase <= PH_COL;
            i     <= k;
            state <= ST_JOB_BASE;
          end else begin
            state <= ST_SRCH_CHK;
          end
        end
        ST_SRCH_CHK: begin
          if (mrd != '0) begin
            i     <= '0;
            state <= ST_FIX_RDA;
          end else begin
            p     <= p + ONE;
            state <= ST_SRCH_RD;
          end
        end
        ST_FIX_RDA: state <= ST_FIX_RDB;
        ST_FIX_RDB: begin
          a_reg <= mrd;
          state <= ST_FIX_WR;
        end
        ST_FIX_WR: begin
          if (i + ONE < n) begin
            i     <= i + ONE;
            state <= ST_FIX_RDA;
          end else begin
            state <= ST_RFIX_RDA;
          end
        end
        ST_RFIX_RDA: state <= ST_RFIX_RDB;
        ST_RFIX_RDB: begin
          a_reg <= vrd;
          state <= ST_RFIX_WR;
        end
        ST_RFIX_WR: begin
          phase <= PH_COL;
          i     <= k;
          state <= ST_JOB_BASE;
        end
        // multiply-accumulate job
        ST_JOB_BASE: begin
          t     <= job_t0;
          state <= ST_JOB_BASEW;
        end
        ST_JOB_BASEW: begin
          acc   <= ACC_W'(job_on_mat ? mrd : vrd);
          state <= job_div ? ST_JOB_DIVW : ST_TERM_A;
        end
        ST_JOB_DIVW: begin
          div_reg <= mrd;
          state   <= ST_TERM_A;
        end
        ST_TERM_A: begin
          state <= (t >= job_tend) ? ST_JOB_FIN : ST_TERM_B;
        end
        ST_TERM_B: begin
          a_reg <= mrd;
          state <= ST_TERM_MUL;
        end
        ST_TERM_MUL: begin
          prod  <= (2*VAL_W)'(a_reg) * (2*VAL_W)'(brd);
          state <= ST_TERM_ACC;
        end
        ST_TERM_ACC: begin
          acc   <= acc - ACC_W'(prod >>> FRAC_W);
          t     <= t + ONE;
          state <= ST_TERM_A;
        end
        ST_JOB_FIN: begin
          res_reg <= acc_sat;
          state   <= job_div ? ST_DIV_WAIT : ST_JOB_WR;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            res_reg <= div_quo;
            if (div_zero) begin
              sing_seen <= 1'b1;
            end
            state <= ST_JOB_WR;
          end
        end
        // advance to the next job
        ST_JOB_WR: begin
          unique case (phase)
            PH_COL: begin
              if (i + ONE < n) begin
                i     <= i + ONE;
                state <= ST_JOB_BASE;
              end else if (k + ONE < n) begin
                phase <= PH_ROW;
                i     <= k + ONE;
                state <= ST_JOB_BASE;
              end else begin
                phase <= PH_FWD;
                i     <= '0;
                state <= ST_JOB_BASE;
              end
            end
            PH_ROW: begin
              if (i + ONE < n) begin
                i     <= i + ONE;
                state <= ST_JOB_BASE;
              end else begin
                k     <= k + ONE;
                state <= ST_PIV_RD;
              end
            end
            PH_FWD: begin
              if (i + ONE < n) begin
                i <= i + ONE;
              end else begin
                phase <= PH_BACK;
                i     <= n - ONE;
              end
              state <= ST_JOB_BASE;
            end
            PH_BACK: begin
              if (i == '0) begin
                state <= ST_OUT_RD;
              end else begin
                i     <= i - ONE;
                state <= ST_JOB_BASE;
              end
            end
          endcase
        end
        // result items
        ST_OUT_RD: state <= ST_OUT_LD;
        ST_OUT_LD: begin
          out_item.index    <= i[IDX_W-1:0];
          out_item.solution <= vrd;
          out_item.last     <= (i + ONE == n);
          out_item.singular <= sing_seen;
          out_valid         <= 1'b1;
          state             <= ST_OUT_WAIT;
        end
        ST_OUT_WAIT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (i + ONE == n) begin
              state <= ST_IDLE;
            end else begin
              i     <= i + ONE;
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_out_only_in_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT_WAIT))
    else $error("result valid outside of output wait");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.last) |-> (out_item.index == IDX_W'(n - ONE)))
    else $error("last flag on wrong index");

  a_term_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TERM_B) |-> (t < job_tend))
    else $error("term index beyond job bound");

  a_singular_src: assert property (@(posedge clk) disable iff (rst)
    $rose(sing_seen) |-> $past(div_done && div_zero))
    else $error("singular set without zero divisor");

endmodule

// ===== tb/lu_decomposition_solve_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lu_decomposition_solve_unit_tb
// Drives load and solve items into the LU solve unit under random idling and
// back-pressure, predicts every solution element with a behavioral Q16.16
// Crout solver and checks the emitted elements in order.
// ----------------------------------------------------------------------------
module lu_decomposition_solve_unit_tb;
  import lus_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 2000;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [31:0] QONE = 32'sh00010000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_write = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;

  lu_decomposition_solve_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] mat [MAX_ORDER][MAX_ORDER];
  logic signed [31:0] rhs [MAX_ORDER];
  logic signed [31:0] fwd [MAX_ORDER];
  logic signed [31:0] sol [MAX_ORDER];
  bit mat_written [MAX_ORDER][MAX_ORDER];
  bit rhs_written [MAX_ORDER];
  bit singular_flag;
  int order = 16;

  out_item_t solutions_due[$];
  int mismatches = 0;
  int cycles = 0;
  bit long_hold = 1'b0;
  bit rx_random = 1'b1;

  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > 64'sh7fffffff) return QMAX;
    if (v < -64'sh80000000) return QMIN;
    return v[31:0];
  endfunction

  // floor of product >> 16 (arithmetic shift rounds toward minus infinity)
  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p >>> 16;
  endfunction

  function automatic logic signed [31:0] qdiv(input logic signed [31:0] num,
                                              input logic signed [31:0] den);
    logic signed [63:0] q;
    if (den == 0) begin
      singular_flag = 1'b1;
      if (num > 0) return QMAX;
      if (num < 0) return QMIN;
      return 0;
    end
    q = (64'(num) <<< 16) / 64'(den);
    return sat(q);
  endfunction

  // in-place crout factor, forward and back substitution
  task automatic solve_system(input int n);
    logic signed [63:0] s;
    singular_flag = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (mat[k][k] == 0) begin
        for (int p = k + 1; p < n; p++) begin
          if (mat[p][k] != 0) begin
            for (int i = 0; i < n; i++) mat[k][i] = sat(64'(mat[k][i]) + 64'(mat[p][i]));
            rhs[k] = sat(64'(rhs[k]) + 64'(rhs[p]));
            break;
          end
        end
      end
      for (int i = k; i < n; i++) begin
        s = 0;
        for (int p = 0; p < k; p++) s += qmul(mat[i][p], mat[p][k]);
        mat[i][k] = sat(64'(mat[i][k]) - s);
      end
      for (int j = k + 1; j < n; j++) begin
        s = 0;
        for (int p = 0; p < k; p++) s += qmul(mat[k][p], mat[p][j]);
        mat[k][j] = qdiv(sat(64'(mat[k][j]) - s), mat[k][k]);
      end
    end
    for (int i = 0; i < n; i++) begin
      s = 0;
      for (int k = 0; k < i; k++) s += qmul(mat[i][k], fwd[k]);
      fwd[i] = qdiv(sat(64'(rhs[i]) - s), mat[i][i]);
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = 0;
      for (int k = i + 1; k < n; k++) s += qmul(mat[i][k], sol[k]);
      sol[i] = sat(64'(fwd[i]) - s);
    end
  endtask

  // apply one accepted item to the predictor
  task automatic predict_item(input in_item_t it);
    out_item_t o;
    case (it.action)
      ACT_MAT: begin
        mat[it.row][it.col] = it.value;
        mat_written[it.row][it.col] = 1'b1;
      end
      ACT_RHS: begin
        rhs[it.row] = it.value;
        rhs_written[it.row] = 1'b1;
      end
      ACT_SOLVE: begin
        solve_system(order);
        for (int i = 0; i < order; i++) begin
          o.index = i[IDX_W-1:0];
          o.solution = sol[i];
          o.last = (i == order - 1);
          o.singular = singular_flag;
          solutions_due.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  function automatic bit all_loaded(input int n);
    for (int r = 0; r < n; r++) begin
      if (!rhs_written[r]) return 1'b0;
      for (int c = 0; c < n; c++) if (!mat_written[r][c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // send one item, waiting for acceptance
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (solutions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_order(input logic [SIZE_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    order = (v < 1) ? 1 : (v > 16 ? 16 : int'(v));
  endtask

  function automatic logic signed [31:0] rand_value(input int style);
    case (style)
      0: return $signed($urandom());
      1: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      2: return $signed($urandom_range(0, 32'h0fffffff)) - 32'sh08000000;
      default: return ($urandom_range(0, 1)) ? QMAX : QMIN;
    endcase
  endfunction

  // load a full system of order n with random content, then solve
  task automatic load_and_solve(input int n, input int style, input bit gaps);
    in_item_t it;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        it.action = ACT_MAT; it.row = r[IDX_W-1:0]; it.col = c[IDX_W-1:0];
        it.value = (r == c) ? rand_value(style) + QONE : rand_value(style);
        if ($urandom_range(0, 15) == 0) it.value = 0;
        send_item(it);
        if (gaps) idle_gap();
      end
      it.action = ACT_RHS; it.row = r[IDX_W-1:0]; it.col = IDX_W'($urandom());
      it.value = rand_value(style);
      send_item(it);
      if (gaps) idle_gap();
    end
    it = '0; it.action = ACT_SOLVE; it.row = IDX_W'($urandom());
    it.col = IDX_W'($urandom());
    it.value = $urandom();
    send_item(it);
    if (gaps) idle_gap();
  endtask

  // directed rows: expected x0 given where obvious from 1x1 systems
  typedef struct {
    logic [1:0] action;
    logic [3:0] row;
    logic [3:0] col;
    logic signed [31:0] value;
    bit typed;
    logic signed [31:0] x0;
    bit sing;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{ACT_MAT,   4'd0, 4'd0, QONE,        1'b0, 32'sd0, 1'b0},
    '{ACT_RHS,   4'd0, 4'd0, QMAX,        1'b0, 32'sd0, 1'b0},
    '{ACT_SOLVE, 4'd0, 4'd0, 32'sd0,      1'b1, QMAX,   1'b0},
    '{ACT_MAT,   4'd0, 4'd0, 32'sd0,      1'b0, 32'sd0, 1'b0},
    '{ACT_RHS,   4'd0, 4'd0, QMIN,        1'b0, 32'sd0, 1'b0},
    '{ACT_SOLVE, 4'd0, 4'd0, 32'sd0,      1'b1, QMIN,   1'b1},
    '{ACT_RHS,   4'd0, 4'd0, 32'sd0,      1'b0, 32'sd0, 1'b0},
    '{ACT_SOLVE, 4'd0, 4'd0, 32'sd0,      1'b1, 32'sd0, 1'b1},
    '{ACT_MAT,   4'd0, 4'd0, 32'sh20000,  1'b0, 32'sd0, 1'b0},
    '{ACT_RHS,   4'd0, 4'd0, 32'sh30000,  1'b0, 32'sd0, 1'b0},
    '{ACT_SOLVE, 4'd0, 4'd0, 32'sd0,      1'b1, 32'sh18000, 1'b0},
    '{ACT_NOP,   4'd15, 4'd15, QMIN,      1'b0, 32'sd0, 1'b0},
    '{ACT_MAT,   4'd15, 4'd15, QMIN,      1'b0, 32'sd0, 1'b0},
    '{ACT_RHS,   4'd15, 4'd15, QMAX,      1'b0, 32'sd0, 1'b0},
    '{ACT_MAT,   4'd0, 4'd0, -32'sh10000, 1'b0, 32'sd0, 1'b0},
    '{ACT_RHS,   4'd0, 4'd0, 32'sh10000,  1'b0, 32'sd0, 1'b0},
    '{ACT_SOLVE, 4'd3, 4'd9, 32'sd5,      1'b1, -32'sh10000, 1'b0}
  };

  // stimulus
  initial begin
    in_item_t it;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part on a 1x1 system
    set_order(5'd0);
    foreach (dir_rows[i]) begin
      it.action = dir_rows[i].action; it.row = dir_rows[i].row;
      it.col = dir_rows[i].col; it.value = dir_rows[i].value;
      send_item(it);
      if (dir_rows[i].typed) begin
        // hand value and predictor must agree
        if (solutions_due[$].solution != dir_rows[i].x0 ||
            solutions_due[$].singular != dir_rows[i].sing) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: hand value %h/%b predictor %h/%b", i,
                     dir_rows[i].x0, dir_rows[i].sing,
                     solutions_due[$].solution, solutions_due[$].singular);
        end
      end
      in_valid <= 1'b0;
      @(posedge clk);
    end
    drain();

    // 2x2 with a zero leading diagonal: row add fix
    set_order(5'd2);
    it.action = ACT_MAT;
    it.row = 4'd0; it.col = 4'd0; it.value = 32'sd0; send_item(it);
    it.row = 4'd0; it.col = 4'd1; it.value = QONE; send_item(it);
    it.row = 4'd1; it.col = 4'd0; it.value = QONE; send_item(it);
    it.row = 4'd1; it.col = 4'd1; it.value = 32'sh20000; send_item(it);
    it.action = ACT_RHS;
    it.row = 4'd0; it.value = 32'sh30000; send_item(it);
    it.row = 4'd1; it.value = -32'sh10000; send_item(it);
    it.action = ACT_SOLVE; send_item(it);
    // solve again on the factored contents
    send_item(it);
    drain();

    // back-pressure: receiver holds while a system loads and solves and a second solve waits
    set_order(5'd3);
    long_hold = 1'b1;
    load_and_solve(3, 1, 1'b0);
    it = '0; it.action = ACT_SOLVE; send_item(it);
    in_valid <= 1'b0;
    long_hold = 1'b0;
    drain();

    // random phases over several orders
    for (int ph = 0; ph < 6; ph++) begin
      n = (ph == 5) ? 5 : $urandom_range(1, 4);
      set_order(n[SIZE_W-1:0]);
      for (int s = 0; s < 2; s++) begin
        load_and_solve(n, $urandom_range(0, 3), 1'b1);
        // occasional noise: dropped action, stray writes beyond n, re-solve
        if ($urandom_range(0, 2) == 0) begin
          it.action = ACT_NOP; it.row = IDX_W'($urandom()); it.col = IDX_W'($urandom());
          it.value = $urandom(); send_item(it);
          it.action = ACT_MAT; it.row = IDX_W'($urandom_range(n, 15));
          it.col = IDX_W'($urandom()); it.value = $urandom();
          if (n < 16) send_item(it);
          if (all_loaded(n)) begin
            it.action = ACT_SOLVE; send_item(it);
          end
        end
      end
      drain();
    end

    if (mismatches == 0 && solutions_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver stall: random, with a long hold counted in cycles
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        hold = 0;
        while (hold < HOLD_CYCLES) begin
          @(posedge clk);
          hold++;
        end
        out_stall <= 1'b0;
        wait (!long_hold);
      end else if (rx_random && $urandom_range(0, 20) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(5, 40)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    out_item_t exp_item;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (solutions_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected solution element %p", out_item);
      end else begin
        exp_item = solutions_due.pop_front();
        if (out_item.index !== exp_item.index ||
            out_item.solution !== exp_item.solution ||
            out_item.last !== exp_item.last ||
            out_item.singular !== exp_item.singular) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected idx %0d x %h last %b sing %b, %s %0d x %h last %b sing %b",
                     exp_item.index, exp_item.solution, exp_item.last, exp_item.singular,
                     "got idx", out_item.index, out_item.solution, out_item.last,
                     out_item.singular);
        end
      end
    end
  end
endmodule
